// File: sv/wsfp_pkg.sv
// Shared types and constants for the WebSocket frame parser.
package wsfp_pkg;

    localparam int BYTE_W     = 8;
    localparam int LEN_W      = 64;
    localparam int KEY_W      = 32;
    localparam int OPCODE_W   = 4;
    localparam int RSV_W      = 3;
    localparam int OUT_DATA_W = 88;
    localparam int OUT_USED_W = 1 + RSV_W + OPCODE_W + 1 + LEN_W + BYTE_W;
    localparam int OUT_PAD_W  = OUT_DATA_W - OUT_USED_W;

    localparam logic [6:0] LEN7_EXT16 = 7'd126;
    localparam logic [6:0] LEN7_EXT64 = 7'd127;
    localparam logic [3:0] EXT16_BYTES = 4'd2;
    localparam logic [3:0] EXT64_BYTES = 4'd8;
    localparam logic [3:0] KEY_BYTES   = 4'd4;

    localparam logic KIND_HEADER  = 1'b0;
    localparam logic KIND_PAYLOAD = 1'b1;

    typedef struct packed {
        logic                kind;
        logic                fin;
        logic [RSV_W-1:0]    rsv;
        logic [OPCODE_W-1:0] opcode;
        logic                masked;
        logic [LEN_W-1:0]    length;
        logic [BYTE_W-1:0]   data;
        logic                last;
    } wsfp_result_t;

endpackage

// File: sv/wsfp_in_stage.sv
// Input register stage holding one raw byte for the parser core.
module wsfp_in_stage
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [wsfp_pkg::BYTE_W-1:0] s_axis_tdata,
    input  logic                        consume,
    output logic                        byte_valid,
    output logic [wsfp_pkg::BYTE_W-1:0] byte_data
);
    import wsfp_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    logic [BYTE_W-1:0] byte_reg;
    logic [BYTE_W-1:0] byte_next;

    assign s_axis_tready = !valid_reg || consume;

    always_comb
    begin
        valid_next = valid_reg;
        byte_next  = byte_reg;
        if (s_axis_tready)
        begin
            valid_next = s_axis_tvalid;
            byte_next  = s_axis_tdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

    assign byte_valid = valid_reg;
    assign byte_data  = byte_reg;

endmodule

// File: sv/wsfp_core.sv
// Frame parse state and per-byte result logic.
module wsfp_core
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        byte_valid,
    input  logic [wsfp_pkg::BYTE_W-1:0] byte_data,
    input  logic                        out_free,
    output logic                        consume,
    output logic                        res_valid,
    output wsfp_pkg::wsfp_result_t      res
);
    import wsfp_pkg::*;

    typedef enum logic [2:0]
    {
        PH_HDR0 = 3'd0,
        PH_HDR1 = 3'd1,
        PH_EXT  = 3'd2,
        PH_KEY  = 3'd3,
        PH_PAY  = 3'd4
    } phase_t;

    phase_t            phase_reg,  phase_next;
    logic [8:0]        flags_reg,  flags_next;
    logic [LEN_W-1:0]  acc_reg,    acc_next;
    logic [3:0]        count_reg,  count_next;
    logic [KEY_W-1:0]  key_reg,    key_next;
    logic [LEN_W-1:0]  remain_reg, remain_next;
    logic [1:0]        kidx_reg,   kidx_next;

    logic              has_result;
    logic              res_kind;
    logic [BYTE_W-1:0] res_data;
    logic              res_last;
    logic [BYTE_W-1:0] key_byte;
    logic [6:0]        len7;
    logic [3:0]        count_dec;
    logic [LEN_W-1:0]  remain_dec;
    logic              hdr_done;
    logic              mask_now;

    assign len7       = byte_data[6:0];
    assign count_dec  = count_reg - 4'd1;
    assign remain_dec = remain_reg - {{(LEN_W-1){1'b0}}, 1'b1};

    always_comb
    begin
        case (kidx_reg)
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    always_comb
    begin
        phase_next  = phase_reg;
        flags_next  = flags_reg;
        acc_next    = acc_reg;
        count_next  = count_reg;
        key_next    = key_reg;
        remain_next = remain_reg;
        kidx_next   = kidx_reg;
        has_result  = 1'b0;
        res_kind    = KIND_HEADER;
        res_data    = '0;
        res_last    = 1'b0;
        hdr_done    = 1'b0;
        mask_now    = flags_reg[0];

        case (phase_reg)
            PH_HDR1:
            begin
                flags_next = {flags_reg[8:1], byte_data[7]};
                mask_now   = byte_data[7];
                acc_next   = '0;
                if (len7 == LEN7_EXT16)
                begin
                    phase_next = PH_EXT;
                    count_next = EXT16_BYTES;
                end
                else if (len7 == LEN7_EXT64)
                begin
                    phase_next = PH_EXT;
                    count_next = EXT64_BYTES;
                end
                else
                begin
                    acc_next = {{(LEN_W-7){1'b0}}, len7};
                    hdr_done = 1'b1;
                end
            end
            PH_EXT:
            begin
                acc_next   = {acc_reg[LEN_W-BYTE_W-1:0], byte_data};
                count_next = count_dec;
                hdr_done   = (count_dec == 4'd0);
            end
            PH_KEY:
            begin
                key_next   = {key_reg[KEY_W-BYTE_W-1:0], byte_data};
                count_next = count_dec;
                if (count_dec == 4'd0)
                begin
                    has_result  = 1'b1;
                    remain_next = acc_reg;
                    kidx_next   = 2'd0;
                    res_last    = (acc_reg == '0);
                    phase_next  = (acc_reg == '0) ? PH_HDR0 : PH_PAY;
                end
            end
            PH_PAY:
            begin
                has_result  = 1'b1;
                res_kind    = KIND_PAYLOAD;
                res_data    = flags_reg[0] ? (byte_data ^ key_byte) : byte_data;
                kidx_next   = kidx_reg + 2'd1;
                remain_next = remain_dec;
                res_last    = (remain_dec == '0);
                if (remain_dec == '0)
                begin
                    phase_next = PH_HDR0;
                end
            end
            default:
            begin
                flags_next = {byte_data, 1'b0};
                count_next = 4'd0;
                phase_next = PH_HDR1;
            end
        endcase

        // length settled: fetch key if masked, otherwise header is complete
        if (hdr_done)
        begin
            key_next = '0;
            if (mask_now)
            begin
                phase_next = PH_KEY;
                count_next = KEY_BYTES;
            end
            else
            begin
                has_result  = 1'b1;
                remain_next = acc_next;
                kidx_next   = 2'd0;
                res_last    = (acc_next == '0);
                phase_next  = (acc_next == '0) ? PH_HDR0 : PH_PAY;
            end
        end
    end

    assign consume   = byte_valid && (!has_result || out_free);
    assign res_valid = consume && has_result;

    always_comb
    begin
        res.kind   = res_kind;
        res.fin    = flags_next[8];
        res.rsv    = flags_next[7:5];
        res.opcode = flags_next[4:1];
        res.masked = flags_next[0];
        res.length = acc_next;
        res.data   = res_data;
        res.last   = res_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HDR0;
            flags_reg  <= '0;
            acc_reg    <= '0;
            count_reg  <= '0;
            key_reg    <= '0;
            remain_reg <= '0;
            kidx_reg   <= '0;
        end
        else if (consume)
        begin
            phase_reg  <= phase_next;
            flags_reg  <= flags_next;
            acc_reg    <= acc_next;
            count_reg  <= count_next;
            key_reg    <= key_next;
            remain_reg <= remain_next;
            kidx_reg   <= kidx_next;
        end
    end

endmodule

// File: sv/wsfp_out_stage.sv
// Output result register driving the master stream.
module wsfp_out_stage
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load,
    input  wsfp_pkg::wsfp_result_t res,
    output logic                   out_free,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output wsfp_pkg::wsfp_result_t out_res
);
    import wsfp_pkg::*;

    logic         valid_reg;
    logic         valid_next;
    wsfp_result_t res_reg;

    assign out_free = !valid_reg || m_axis_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign out_res       = res_reg;

endmodule

// File: sv/websocket_frame_parser.sv
// Top level: WebSocket frame parser, one stream byte per beat.
// Path: an accepted byte waits in the input register; its result is registered in the output stage.
// Throughput: one byte per cycle while the output can take results; bytes that produce no result move on
// even while a result waits on the output.
// Reset: rst_n async, clears parse state to expect a first header byte.
module websocket_frame_parser
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [wsfp_pkg::BYTE_W-1:0]     s_axis_tdata,   // in_byte
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // fin_flag, rsv_bits, frame_opcode, masked_flag, frame_length, data_byte, zero pad
    output logic [wsfp_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    output logic [0:0]                      m_axis_tuser,   // result_kind
    output logic                            m_axis_tlast
);
    import wsfp_pkg::*;

    logic              byte_valid;
    logic [BYTE_W-1:0] byte_data;
    logic              consume;
    logic              res_valid;
    logic              out_free;
    wsfp_result_t      res;
    wsfp_result_t      out_res;

    wsfp_in_stage u_in
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .consume       (consume),
        .byte_valid    (byte_valid),
        .byte_data     (byte_data)
    );

    wsfp_core u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_data  (byte_data),
        .out_free   (out_free),
        .consume    (consume),
        .res_valid  (res_valid),
        .res        (res)
    );

    wsfp_out_stage u_out
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (res_valid),
        .res           (res),
        .out_free      (out_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .out_res       (out_res)
    );

    assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, out_res.data, out_res.length, out_res.masked,
                           out_res.opcode, out_res.rsv, out_res.fin};
    assign m_axis_tuser = out_res.kind;
    assign m_axis_tlast = out_res.last;

endmodule
